// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the word frequency table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/wft_pkg.sv =====
// Package for the word frequency table: sequencer states, opcodes and fixed field widths.
// Depends on nothing; imported by every module of the block.
package wft_pkg;

  localparam int LEN_W     = 5;
  localparam int TEXT_BITS = 160;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 208;
  localparam int IDXO_W    = 6;

  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_EOT  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN_CMP,
    ST_MISS,
    ST_READ_REQ,
    ST_READ_CMP,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic hit;
    logic at_max;
  } match_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage

// ===== rtl/word_frequency_table.sv =====
// Word frequency table top level: byte stream in, counted or read entries out.
// Depends on wft_pkg, assert_macros.svh, wft_entry_mem and wft_match.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  opcode (tuser); character, read_index (tdata)
//   m_*       out   m_tvalid/m_tready  entry result
//   apb       in    psel/penable       report_threshold at address 0
//
// A letter or an idle separator leaves the sequencer in idle. A word end scans
// the table through the single read port, one stored entry per request and
// compare, then updates and loads. A read passes its request, compare and load.
// Reset clears the fill count; no clearing pass runs over the store.
// A stalled output holds the sequencer in its load state.
`include "assert_macros.svh"
module word_frequency_table #(
  parameter int TABLE_DEPTH      = 64,
  parameter int MAX_WORD_LETTERS = 20,
  parameter int COUNT_BITS       = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // opcode[1:0]
  input  logic [1:0]                 s_tuser,
  // character[7:0], read_index[13:8]
  input  logic [wft_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // entry_index[5:0], word_length[10:6], letters_low[74:11], letters_mid[138:75],
  // letters_high[170:139], occurrences[202:171], newly_added[203],
  // above_threshold[204], table_full[205], truncated[206], entry_valid[207]
  output logic [wft_pkg::OUT_W-1:0]  m_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wft_pkg::*;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EU_W    = $clog2(TABLE_DEPTH + 1);
  localparam int PL_W    = $clog2(MAX_WORD_LETTERS);
  localparam int LW      = 8 * MAX_WORD_LETTERS;
  localparam int ENTRY_W = COUNT_BITS + LEN_W + LW;

  state_t state, state_next;

  logic [31:0]          report_threshold;
  logic [7:0]           pending_letters [MAX_WORD_LETTERS];
  logic [LEN_W-1:0]     pending_length;
  logic                 pending_truncated;
  logic [EU_W-1:0]      entries_used;

  logic [LEN_W-1:0]     word_len;
  logic [LW-1:0]        word_bits;
  logic [LW-1:0]        pend_masked;
  logic                 word_trunc;
  logic [IDX_W-1:0]     scan_index;
  logic                 read_ok;

  logic [LEN_W-1:0]     res_len;
  logic [LW-1:0]        res_bits;
  logic [COUNT_BITS-1:0] res_count;
  logic [IDXO_W-1:0]    res_idx;
  logic                 res_new, res_full, res_trunc, res_valid;

  logic [ENTRY_W-1:0]   rdata;
  logic [ENTRY_W-1:0]   wdata;
  logic [IDX_W-1:0]     waddr;
  logic                 we;
  logic [COUNT_BITS-1:0] ent_count;
  logic [LEN_W-1:0]     ent_len;
  logic [LW-1:0]        ent_bits;
  match_t               match;
  logic [COUNT_BITS-1:0] count_next;

  logic                 accept, is_word_end, scan_last, load_go, cfg_wr;
  logic [7:0]           in_char;
  logic [1:0]           in_op;
  logic [IDXO_W-1:0]    in_idx;
  logic [TEXT_BITS-1:0] out_text;

  assign in_op   = s_tuser;
  assign in_char = s_tdata[7:0];
  assign in_idx  = s_tdata[13:8];
  assign accept  = s_tvalid && s_tready;
  assign is_word_end = (pending_length != '0) &&
                       ((in_op == OP_EOT) || ((in_op == OP_TEXT) && !is_letter(in_char)));
  assign {ent_count, ent_len, ent_bits} = rdata;
  assign scan_last = ((EU_W'(scan_index) + EU_W'(1)) == entries_used);
  assign load_go   = !m_tvalid || m_tready;
  assign read_ok   = ({7'd0, in_idx} < 13'(entries_used));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? report_threshold : 32'd0;

  always_comb begin
    for (int i = 0; i < MAX_WORD_LETTERS; i++) begin
      pend_masked[8*i +: 8] = (LEN_W'(i) < pending_length) ? pending_letters[i] : 8'd0;
    end
  end

  wft_entry_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(scan_index), .rdata(rdata)
  );

  wft_match #(.LW(LW), .CW(COUNT_BITS)) u_match (
    .word_len(word_len), .word_bits(word_bits),
    .entry_len(ent_len), .entry_bits(ent_bits), .entry_count(ent_count),
    .result(match), .count_next(count_next)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ) begin
            state_next = ST_READ_REQ;
          end else if (is_word_end) begin
            state_next = (entries_used == '0) ? ST_MISS : ST_SCAN_REQ;
          end
        end
      end
      ST_SCAN_REQ: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (match.hit) begin
          state_next = ST_LOAD;
        end else if (scan_last) begin
          state_next = ST_MISS;
        end else begin
          state_next = ST_SCAN_REQ;
        end
      end
      ST_MISS:     state_next = ST_LOAD;
      ST_READ_REQ: state_next = ST_READ_CMP;
      ST_READ_CMP: state_next = ST_LOAD;
      ST_LOAD:     state_next = load_go ? ST_IDLE : ST_LOAD;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    we       = 1'b0;
    waddr    = scan_index;
    wdata    = {count_next, ent_len, ent_bits};
    case (state)
      ST_SCAN_CMP: we = match.hit;
      ST_MISS: begin
        we    = (entries_used != EU_W'(TABLE_DEPTH));
        waddr = IDX_W'(entries_used);
        wdata = {COUNT_BITS'(1), word_len, word_bits};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      report_threshold  <= 32'd5;
      pending_length    <= '0;
      pending_truncated <= 1'b0;
      entries_used      <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        report_threshold <= pwdata;
      end
      if (state == ST_IDLE && accept && in_op == OP_TEXT && is_letter(in_char)) begin
        if (pending_length < LEN_W'(MAX_WORD_LETTERS)) begin
          pending_length <= pending_length + LEN_W'(1);
        end else begin
          pending_truncated <= 1'b1;
        end
      end
      if (state == ST_IDLE && accept && is_word_end) begin
        pending_length    <= '0;
        pending_truncated <= 1'b0;
      end
      if (state == ST_MISS && entries_used != EU_W'(TABLE_DEPTH)) begin
        entries_used <= entries_used + EU_W'(1);
      end
      if (state == ST_LOAD && load_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && in_op == OP_TEXT && is_letter(in_char) &&
        pending_length < LEN_W'(MAX_WORD_LETTERS)) begin
      pending_letters[pending_length[PL_W-1:0]] <= in_char;
    end
    case (state)
      ST_IDLE: begin
        word_len   <= pending_length;
        word_bits  <= pend_masked;
        word_trunc <= pending_truncated;
        if (in_op == OP_READ) begin
          scan_index <= IDX_W'(in_idx);
          res_idx    <= in_idx;
          res_valid  <= read_ok;
        end else begin
          scan_index <= '0;
        end
      end
      ST_SCAN_CMP: begin
        if (match.hit) begin
          res_idx   <= IDXO_W'(scan_index);
          res_len   <= word_len;
          res_bits  <= word_bits;
          res_count <= count_next;
          res_new   <= 1'b0;
          res_full  <= 1'b0;
          res_trunc <= word_trunc;
          res_valid <= 1'b1;
        end else begin
          scan_index <= scan_index + IDX_W'(1);
        end
      end
      ST_MISS: begin
        res_len   <= word_len;
        res_bits  <= word_bits;
        res_trunc <= word_trunc;
        if (entries_used != EU_W'(TABLE_DEPTH)) begin
          res_idx   <= IDXO_W'(entries_used);
          res_count <= COUNT_BITS'(1);
          res_new   <= 1'b1;
          res_full  <= 1'b0;
          res_valid <= 1'b1;
        end else begin
          res_idx   <= '0;
          res_count <= '0;
          res_new   <= 1'b0;
          res_full  <= 1'b1;
          res_valid <= 1'b0;
        end
      end
      ST_READ_CMP: begin
        res_new   <= 1'b0;
        res_full  <= 1'b0;
        res_trunc <= 1'b0;
        res_len   <= res_valid ? ent_len : '0;
        res_bits  <= res_valid ? ent_bits : '0;
        res_count <= res_valid ? ent_count : '0;
      end
      default: ;
    endcase
    if (state == ST_LOAD && load_go) begin
      m_tdata <= {res_valid, res_trunc, res_full,
                  res_valid && (32'(res_count) > report_threshold),
                  res_new, 32'(res_count),
                  out_text, res_len,
                  (state == ST_LOAD && res_full) ? IDXO_W'(0) : IDXO_W'(res_idx)};
    end
  end

  assign out_text = TEXT_BITS'(res_bits);

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, entries_used <= EU_W'(TABLE_DEPTH))
  `ASSERT_IMPL(a_write_src, clk, rst, we, state == ST_SCAN_CMP || state == ST_MISS)
  `ASSERT_IMPL(a_fill_step, clk, rst, $past(entries_used) != entries_used && !$past(rst),
               $past(state) == ST_MISS && entries_used == $past(entries_used) + EU_W'(1))
  `ASSERT_IMPL(a_busy_stall, clk, rst, state != ST_IDLE, !s_tready)

endmodule

// ===== rtl/wft_entry_mem.sv =====
// Table store: one entry per stored word holding count, length and letters.
// Depends on wft_pkg; one write port, one registered read port.
module wft_entry_mem #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 197
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import wft_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wft_match.sv =====
// Shared compare and increment unit: tests one stored entry against the word.
// Depends on wft_pkg; used once per scanned entry by the sequencer.
module wft_match #(
  parameter int LW = 160,
  parameter int CW = 32
) (
  input  logic [wft_pkg::LEN_W-1:0] word_len,
  input  logic [LW-1:0]             word_bits,
  input  logic [wft_pkg::LEN_W-1:0] entry_len,
  input  logic [LW-1:0]             entry_bits,
  input  logic [CW-1:0]             entry_count,
  output wft_pkg::match_t           result,
  output logic [CW-1:0]             count_next
);
  import wft_pkg::*;

  always_comb begin
    result.hit    = (word_len == entry_len) && (word_bits == entry_bits);
    result.at_max = &entry_count;
    count_next    = result.at_max ? entry_count : entry_count + CW'(1);
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for word_frequency_table: a directed table, then random text.
// Depends on wft_pkg and the word_frequency_table RTL; expected entries come from a
// behavioural copy of the word table held here.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wft_pkg::*;

  localparam int DEPTH = 64;
  localparam int MAXL  = 20;
  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

  typedef struct packed {
    logic        entry_valid;
    logic        truncated;
    logic        table_full;
    logic        above_threshold;
    logic        newly_added;
    logic [31:0] occurrences;
    logic [31:0] letters_high;
    logic [63:0] letters_mid;
    logic [63:0] letters_low;
    logic [4:0]  word_length;
    logic [5:0]  entry_index;
  } entry_rpt_t;

  typedef struct packed {
    logic [5:0] read_index;
    logic [7:0] character;
    logic [1:0] opcode;
  } text_item_t;

  typedef struct {
    text_item_t  item;
    bit          known;
    entry_rpt_t  rpt;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [1:0] s_tuser = '0;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  word_frequency_table dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // word table copy
  logic [31:0] threshold;
  logic [7:0]  word_buf [MAXL];
  int          word_len;
  bit          word_trunc;
  logic [7:0]  tbl_letters [DEPTH][MAXL];
  int          tbl_len [DEPTH];
  logic [31:0] tbl_count [DEPTH];
  int          used;

  entry_rpt_t  expected_entries [$];
  int          fails = 0;
  int          items_sent = 0;
  bit          no_idle = 0;
  bit          hold_off = 0;

  function automatic void pack_word(input logic [7:0] w [MAXL], input int n,
                                    inout entry_rpt_t r);
    logic [159:0] all;
    all = '0;
    for (int i = 0; i < n; i++) all[8*i +: 8] = w[i];
    r.letters_low  = all[63:0];
    r.letters_mid  = all[127:64];
    r.letters_high = all[159:128];
  endfunction

  function automatic entry_rpt_t close_word();
    entry_rpt_t r;
    int e;
    bit hit;
    r = '0;
    hit = 0;
    r.word_length = 5'(word_len);
    r.truncated = word_trunc;
    pack_word(word_buf, word_len, r);
    for (e = 0; e < used; e++) begin
      if (tbl_len[e] == word_len) begin
        hit = 1;
        for (int i = 0; i < word_len; i++)
          if (tbl_letters[e][i] != word_buf[i]) hit = 0;
        if (hit) break;
      end
    end
    if (hit) begin
      if (tbl_count[e] != 32'hFFFF_FFFF) tbl_count[e]++;
    end else if (used < DEPTH) begin
      e = used;
      for (int i = 0; i < MAXL; i++) tbl_letters[e][i] = (i < word_len) ? word_buf[i] : 8'h00;
      tbl_len[e] = word_len;
      tbl_count[e] = 1;
      used++;
      r.newly_added = 1;
    end else begin
      r.table_full = 1;
      word_len = 0;
      word_trunc = 0;
      return r;
    end
    r.entry_index = e[5:0];
    r.occurrences = tbl_count[e];
    r.above_threshold = tbl_count[e] > threshold;
    r.entry_valid = 1;
    word_len = 0;
    word_trunc = 0;
    return r;
  endfunction

  function automatic bit predict_entry(input text_item_t it, output entry_rpt_t r);
    logic [7:0] c;
    r = '0;
    c = it.character;
    case (it.opcode)
      OP_TEXT: begin
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
          if (word_len < MAXL) word_buf[word_len++] = c;
          else word_trunc = 1;
          return 0;
        end
        if (word_len == 0) return 0;
        r = close_word();
        return 1;
      end
      OP_EOT: begin
        if (word_len == 0) return 0;
        r = close_word();
        return 1;
      end
      OP_READ: begin
        r.entry_index = it.read_index;
        if (it.read_index < used) begin
          r.word_length = 5'(tbl_len[it.read_index]);
          pack_word(tbl_letters[it.read_index], tbl_len[it.read_index], r);
          r.occurrences = tbl_count[it.read_index];
          r.above_threshold = tbl_count[it.read_index] > threshold;
          r.entry_valid = 1;
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic write_threshold(input logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_THRESHOLD; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    threshold = v;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 0;
    while (expected_entries.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * DEPTH + 20) @(posedge clk);
  endtask

  task automatic send_item(input text_item_t it, input bit known, input entry_rpt_t ref_rpt);
    entry_rpt_t r;
    bit has;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= it.opcode;
    s_tdata  <= {2'b00, it.read_index, it.character};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    has = predict_entry(it, r);
    if (has) begin
      if (known && r != ref_rpt) begin
        $error("directed row disagrees with predictor: exp %h got %h", ref_rpt, r);
        fails++;
      end
      expected_entries.push_back(r);
    end
  endtask

  function automatic text_item_t mk(input logic [1:0] op, input logic [7:0] c,
                                    input logic [5:0] ix);
    text_item_t t;
    t.opcode = op; t.character = c; t.read_index = ix;
    return t;
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  task automatic send_word(input int n, input int vocab);
    entry_rpt_t z;
    int pick;
    z = '0;
    pick = $urandom_range(0, vocab);
    for (int i = 0; i < n; i++)
      send_item(mk(OP_TEXT, 8'("a" + ((pick + i * 7) % 26)) ^ (i == 2 ? 8'h20 : 8'h00),
                   6'($urandom)), 0, z);
    if ($urandom_range(0, 9) == 0)
      send_item(mk(OP_TEXT, 8'($urandom_range(0, 255)), 6'($urandom)), 0, z);
    send_item(mk($urandom_range(0, 4) == 0 ? OP_EOT : OP_TEXT,
                 $urandom_range(0, 1) ? " " : 8'h2C, 6'($urandom)), 0, z);
  endtask

  task automatic send_rand_word(input int n);
    entry_rpt_t z;
    logic [7:0] sep;
    z = '0;
    for (int i = 0; i < n; i++)
      send_item(mk(OP_TEXT, rand_letter(), 6'($urandom)), 0, z);
    sep = 8'($urandom_range(0, 64));
    send_item(mk($urandom_range(0, 3) == 0 ? OP_EOT : OP_TEXT, sep, 6'($urandom)), 0, z);
  endtask

  // output side
  always @(posedge clk) begin
    entry_rpt_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_entries.size() == 0) begin
        $error("unexpected entry %h", got);
        fails++;
      end else begin
        exp_r = expected_entries.pop_front();
        if (got.entry_index != exp_r.entry_index) begin
          $error("entry_index exp %0d got %0d", exp_r.entry_index, got.entry_index); fails++;
        end
        if (got.word_length != exp_r.word_length) begin
          $error("word_length exp %0d got %0d", exp_r.word_length, got.word_length); fails++;
        end
        if (got.letters_low != exp_r.letters_low) begin
          $error("letters_low exp %h got %h", exp_r.letters_low, got.letters_low); fails++;
        end
        if (got.letters_mid != exp_r.letters_mid) begin
          $error("letters_mid exp %h got %h", exp_r.letters_mid, got.letters_mid); fails++;
        end
        if (got.letters_high != exp_r.letters_high) begin
          $error("letters_high exp %h got %h", exp_r.letters_high, got.letters_high); fails++;
        end
        if (got.occurrences != exp_r.occurrences) begin
          $error("occurrences exp %0d got %0d", exp_r.occurrences, got.occurrences); fails++;
        end
        if (got.newly_added != exp_r.newly_added) begin
          $error("newly_added exp %0b got %0b", exp_r.newly_added, got.newly_added); fails++;
        end
        if (got.above_threshold != exp_r.above_threshold) begin
          $error("above_threshold exp %0b got %0b", exp_r.above_threshold,
                 got.above_threshold); fails++;
        end
        if (got.table_full != exp_r.table_full) begin
          $error("table_full exp %0b got %0b", exp_r.table_full, got.table_full); fails++;
        end
        if (got.truncated != exp_r.truncated) begin
          $error("truncated exp %0b got %0b", exp_r.truncated, got.truncated); fails++;
        end
        if (got.entry_valid != exp_r.entry_valid) begin
          $error("entry_valid exp %0b got %0b", exp_r.entry_valid, got.entry_valid); fails++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        n = 0;
        while (n < 600) begin
          @(posedge clk);
          n++;
        end
        hold_off = 0;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #50ms;
    $display("tb failed");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    entry_rpt_t z, e;
    bit held;
    z = '0;
    held = 0;
    threshold = 5;
    word_len = 0;
    word_trunc = 0;
    used = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reads of an empty table, then letter-boundary characters and reads of the entries
    e = '0; e.entry_index = 6'd63;
    rows.push_back('{mk(OP_READ, 8'hFF, 6'd63), 1, e});
    e = '0;
    rows.push_back('{mk(OP_READ, 8'h00, 6'd0), 1, e});
    rows.push_back('{mk(OP_TEXT, " ", 6'd0), 0, z});
    rows.push_back('{mk(OP_EOT, 8'h00, 6'd0), 0, z});
    rows.push_back('{mk(OP_RSVD, "a", 6'd5), 0, z});
    rows.push_back('{mk(OP_TEXT, "A", 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, "z", 6'd0), 0, z});
    e = '0; e.word_length = 2; e.letters_low = 64'h7A41; e.occurrences = 1;
    e.newly_added = 1; e.entry_valid = 1;
    rows.push_back('{mk(OP_TEXT, 8'hFF, 6'd0), 1, e});
    rows.push_back('{mk(OP_TEXT, 8'h40, 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, "Z", 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, "a", 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, 8'h5B, 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, "A", 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, "z", 6'd0), 0, z});
    rows.push_back('{mk(OP_EOT, 8'h00, 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, 8'h60, 6'd0), 0, z});
    rows.push_back('{mk(OP_TEXT, "{", 6'd0), 0, z});
    rows.push_back('{mk(OP_READ, 8'h00, 6'd0), 0, z});
    rows.push_back('{mk(OP_READ, 8'h00, 6'd1), 0, z});
    rows.push_back('{mk(OP_READ, 8'h00, 6'd2), 0, z});
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].rpt);
    drain();
    write_threshold(32'd2);

    // repeated words from a small vocabulary, reads and reserved opcodes, with one long receiver hold
    while (items_sent < 520) begin
      if (!held && items_sent >= 200) begin
        held = 1;
        hold_off = 1;
      end
      if ($urandom_range(0, 11) == 0)
        send_item(mk(OP_READ, 8'($urandom), 6'($urandom_range(0, 40))), 0, z);
      else if ($urandom_range(0, 29) == 0)
        send_item(mk(OP_RSVD, rand_letter(), 6'($urandom)), 0, z);
      else
        send_word($urandom_range(1, 6), 12);
    end

    // random words, long ones included, and reads, until a thousand items have been sent
    while (items_sent < 1000) begin
      if ($urandom_range(0, 7) == 0)
        send_item(mk(OP_READ, 8'($urandom), 6'($urandom)), 0, z);
      else
        send_rand_word($urandom_range(1, 24));
    end
    drain();
    write_threshold(32'd0);
    no_idle = 1;

    // back to back: every entry, then more vocabulary words
    for (int i = 0; i < DEPTH; i++) send_item(mk(OP_READ, 8'h00, 6'(i)), 0, z);
    while (items_sent < 1250) send_word($urandom_range(1, 5), 6);
    send_item(mk(OP_EOT, 8'h00, 6'd0), 0, z);
    drain();

    if (fails == 0 && expected_entries.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wft_pkg.sv
rtl/wft_entry_mem.sv
rtl/wft_match.sv
rtl/word_frequency_table.sv
verif/tb.sv
